// ===== hw/rtl/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on clk, off while rst is high.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Condition that must never be seen on a clock edge outside reset.
`define ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

// ===== hw/rtl/hkds_pkg.sv =====
package hkds_pkg;

  localparam int unsigned SLOTS_DEF   = 1024;
  localparam int unsigned KEY_W       = 64;
  localparam int unsigned STATUS_W    = 2;
  localparam int unsigned OUT_SLOT_W  = 10;
  localparam int unsigned COUNT_W     = 11;
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned HASH_SHIFT  = 33;

  localparam logic [KEY_W-1:0] HASH_MUL = 64'hff51afd7ed558ccd;

  typedef enum logic [STATUS_W-1:0] {
    ST_INSERTED = 2'd0,
    ST_PRESENT  = 2'd1,
    ST_ZERO     = 2'd2,
    ST_FULL     = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_PROBE
  } back_state_t;

endpackage

// ===== hw/rtl/hkds_fifo.sv =====
module hkds_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = hkds_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             full,
  output logic             empty
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

  logic [WIDTH-1:0] entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] fill;
  logic             do_wr;
  logic             do_rd;

  assign full    = (fill == CNT_W'(DEPTH));
  assign empty   = (fill == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      entries[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        fill <= fill + 1'b1;
      end else if (do_rd && !do_wr) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

// ===== hw/rtl/hkds_front.sv =====
module hkds_front #(
  parameter int unsigned SLOTS = hkds_pkg::SLOTS_DEF,
  localparam int unsigned SLOT_W = $clog2(SLOTS),
  localparam int unsigned JOB_W = hkds_pkg::KEY_W + 1 + SLOT_W
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      push,
  input  logic [hkds_pkg::KEY_W-1:0] key,
  input  logic                      hold,
  output logic                      full,
  output logic                      q_push,
  output logic [JOB_W-1:0]          q_data,
  input  logic                      q_full
);

  localparam logic [31:0] C_LO = hkds_pkg::HASH_MUL[31:0];
  localparam logic [31:0] C_HI = hkds_pkg::HASH_MUL[63:32];

  logic                        s1_valid;
  logic [hkds_pkg::KEY_W-1:0]  s1_key;
  logic [hkds_pkg::KEY_W-1:0]  s1_x;
  logic                        s2_valid;
  logic [hkds_pkg::KEY_W-1:0]  s2_key;
  logic [63:0]                 s2_p0;
  logic [31:0]                 s2_p1;
  logic [31:0]                 s2_p2;
  logic                        adv;
  logic                        take;
  logic [63:0]                 h;
  logic [63:0]                 m;

  assign adv  = !(s2_valid && q_full);
  assign full = hold || !adv;
  assign take = push && !full;

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_key <= key;
      s1_x   <= key ^ (key >> hkds_pkg::HASH_SHIFT);
      s2_key <= s1_key;
      s2_p0  <= {32'b0, s1_x[31:0]} * {32'b0, C_LO};
      s2_p1  <= 32'(s1_x[63:32] * C_LO);
      s2_p2  <= 32'(s1_x[31:0] * C_HI);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= take;
      s2_valid <= s1_valid;
    end
  end

  assign h      = s2_p0 + {s2_p1 + s2_p2, 32'b0};
  assign m      = h ^ (h >> hkds_pkg::HASH_SHIFT);
  assign q_push = s2_valid && !q_full;
  assign q_data = {s2_key, (s2_key == '0), m[SLOT_W-1:0]};

endmodule

// ===== hw/rtl/hkds_back.sv =====
`include "assert_macros.svh"

module hkds_back #(
  parameter int unsigned SLOTS = hkds_pkg::SLOTS_DEF,
  localparam int unsigned SLOT_W = $clog2(SLOTS),
  localparam int unsigned JOB_W = hkds_pkg::KEY_W + 1 + SLOT_W
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             job_valid,
  input  logic [JOB_W-1:0]                 job_data,
  output logic                             job_take,
  output logic                             busy,
  input  logic                             pop,
  output logic                             empty,
  output logic [hkds_pkg::STATUS_W-1:0]    status,
  output logic [hkds_pkg::OUT_SLOT_W-1:0]  slot_index,
  output logic [hkds_pkg::COUNT_W-1:0]     entry_count
);

  localparam logic [31:0]       FULL_AT = 32'(SLOTS * 3 / 4 - 1);
  localparam logic [SLOT_W-1:0] LAST    = SLOT_W'(SLOTS - 1);

  logic [hkds_pkg::KEY_W-1:0] mem [SLOTS];

  hkds_pkg::back_state_t        state, state_next;
  logic [SLOT_W-1:0]            clr_idx, clr_idx_next;
  logic [hkds_pkg::KEY_W-1:0]   cur_key, cur_key_next;
  logic [SLOT_W-1:0]            idx, idx_next;
  logic [SLOT_W-1:0]            probe, probe_next;
  logic [hkds_pkg::COUNT_W-1:0] count, count_next;
  logic                         res_valid, res_valid_next;
  hkds_pkg::status_t            res_status, res_status_next;
  logic [SLOT_W-1:0]            res_slot, res_slot_next;
  logic [hkds_pkg::COUNT_W-1:0] res_count, res_count_next;
  logic [hkds_pkg::KEY_W-1:0]   rdata;

  logic                         mem_we;
  logic [SLOT_W-1:0]            mem_wa;
  logic [hkds_pkg::KEY_W-1:0]   mem_wd;
  logic [SLOT_W-1:0]            rd_addr;
  logic                         out_free;

  logic [hkds_pkg::KEY_W-1:0]   job_key;
  logic                         job_zero;
  logic [SLOT_W-1:0]            job_home;

  assign job_key  = job_data[JOB_W-1 -: hkds_pkg::KEY_W];
  assign job_zero = job_data[SLOT_W];
  assign job_home = job_data[SLOT_W-1:0];
  assign out_free = !res_valid || pop;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rdata <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= hkds_pkg::BK_CLEAR;
      clr_idx   <= '0;
      count     <= '0;
      res_valid <= 1'b0;
    end else begin
      state     <= state_next;
      clr_idx   <= clr_idx_next;
      count     <= count_next;
      res_valid <= res_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    cur_key    <= cur_key_next;
    idx        <= idx_next;
    probe      <= probe_next;
    res_status <= res_status_next;
    res_slot   <= res_slot_next;
    res_count  <= res_count_next;
  end

  always_comb begin
    state_next      = state;
    clr_idx_next    = clr_idx;
    cur_key_next    = cur_key;
    idx_next        = idx;
    probe_next      = probe;
    count_next      = count;
    res_valid_next  = res_valid && !pop;
    res_status_next = res_status;
    res_slot_next   = res_slot;
    res_count_next  = res_count;
    mem_we          = 1'b0;
    mem_wa          = idx;
    mem_wd          = cur_key;
    rd_addr         = idx;
    job_take        = 1'b0;

    case (state)
      hkds_pkg::BK_CLEAR: begin
        mem_we       = 1'b1;
        mem_wa       = clr_idx;
        mem_wd       = '0;
        clr_idx_next = clr_idx + 1'b1;
        if (clr_idx == LAST) begin
          state_next = hkds_pkg::BK_IDLE;
        end
      end
      hkds_pkg::BK_IDLE: begin
        if (job_valid && out_free) begin
          job_take = 1'b1;
          if (job_zero) begin
            res_valid_next  = 1'b1;
            res_status_next = hkds_pkg::ST_ZERO;
            res_slot_next   = '0;
            res_count_next  = count;
          end else begin
            cur_key_next = job_key;
            idx_next     = job_home;
            probe_next   = '0;
            rd_addr      = job_home;
            state_next   = hkds_pkg::BK_PROBE;
          end
        end
      end
      hkds_pkg::BK_PROBE: begin
        if (rdata == cur_key) begin
          res_valid_next  = 1'b1;
          res_status_next = hkds_pkg::ST_PRESENT;
          res_slot_next   = idx;
          res_count_next  = count;
          state_next      = hkds_pkg::BK_IDLE;
        end else if (rdata == '0) begin
          res_valid_next = 1'b1;
          state_next     = hkds_pkg::BK_IDLE;
          if (32'(count) >= FULL_AT) begin
            res_status_next = hkds_pkg::ST_FULL;
            res_slot_next   = '0;
            res_count_next  = count;
          end else begin
            mem_we          = 1'b1;
            count_next      = count + 1'b1;
            res_status_next = hkds_pkg::ST_INSERTED;
            res_slot_next   = idx;
            res_count_next  = count + 1'b1;
          end
        end else if (probe == LAST) begin
          res_valid_next  = 1'b1;
          res_status_next = hkds_pkg::ST_FULL;
          res_slot_next   = '0;
          res_count_next  = count;
          state_next      = hkds_pkg::BK_IDLE;
        end else begin
          idx_next   = idx + 1'b1;
          probe_next = probe + 1'b1;
          rd_addr    = idx + 1'b1;
        end
      end
      default: begin
        state_next = hkds_pkg::BK_IDLE;
      end
    endcase
  end

  assign busy        = (state == hkds_pkg::BK_CLEAR);
  assign empty       = !res_valid;
  assign status      = res_status;
  assign slot_index  = hkds_pkg::OUT_SLOT_W'(res_slot);
  assign entry_count = res_count;

  `ASSERT_NEVER(a_take_in_clear, busy && job_take, "job taken during clear pass")
  `ASSERT_NEVER(a_probe_with_result, (state == hkds_pkg::BK_PROBE) && res_valid, "result held while probing")
  `ASSERT_CLK(a_count_moves, 1'b1 |=> (count == $past(count)) || ((count == $past(count) + 1'b1) && $past(mem_we) && ($past(state) == hkds_pkg::BK_PROBE)), "count changed without insert")
  `ASSERT_CLK(a_insert_nonzero, (state == hkds_pkg::BK_PROBE) && mem_we |-> (mem_wd != '0) && (rdata == '0), "insert into occupied slot or of zero key")

endmodule

// ===== hw/rtl/hashed_key_dedup_set_core.sv =====
// Dedup set of 64-bit keys, open addressing with linear probing in a SLOTS x 64 RAM
// (SLOTS a power of two). After reset the RAM is cleared, one slot per cycle; full
// stays high until that pass is done. Each key gives one result: inserted, already
// present, zero key ignored, or table full (an insert that would bring the count to
// three quarters of SLOTS is refused). The hash is computed in the front pipeline
// registers s1 and s2 and then waits in a four-entry queue. The probe engine takes a
// key while idle, once the last result is popped, then reads one slot per cycle until
// it finds the key, an empty slot or has read every slot. A zero key is answered
// without probing. The single RAM read port sets the probing rate.
module hashed_key_dedup_set_core #(
  parameter int unsigned SLOTS = hkds_pkg::SLOTS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             push,
  output logic                             full,
  input  logic [hkds_pkg::KEY_W-1:0]       key,
  output logic                             empty,
  input  logic                             pop,
  output logic [hkds_pkg::STATUS_W-1:0]    status,
  output logic [hkds_pkg::OUT_SLOT_W-1:0]  slot_index,
  output logic [hkds_pkg::COUNT_W-1:0]     entry_count
);

  localparam int unsigned SLOT_W = $clog2(SLOTS);
  localparam int unsigned JOB_W  = hkds_pkg::KEY_W + 1 + SLOT_W;

  logic             busy;
  logic             q_push;
  logic [JOB_W-1:0] q_wdata;
  logic             q_full;
  logic             q_empty;
  logic [JOB_W-1:0] q_rdata;
  logic             job_take;

  hkds_front #(
    .SLOTS(SLOTS)
  ) u_front (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .key    (key),
    .hold   (busy),
    .full   (full),
    .q_push (q_push),
    .q_data (q_wdata),
    .q_full (q_full)
  );

  hkds_fifo #(
    .WIDTH(JOB_W),
    .DEPTH(hkds_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (q_push),
    .wr_data (q_wdata),
    .rd_en   (job_take),
    .rd_data (q_rdata),
    .full    (q_full),
    .empty   (q_empty)
  );

  hkds_back #(
    .SLOTS(SLOTS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .job_valid   (!q_empty),
    .job_data    (q_rdata),
    .job_take    (job_take),
    .busy        (busy),
    .pop         (pop),
    .empty       (empty),
    .status      (status),
    .slot_index  (slot_index),
    .entry_count (entry_count)
  );

endmodule
